@@ rtl/rolz_pkg.sv @@
// rolz_pkg: constants, word types and field widths for the reduced-offset lz token decoder
// used by rolz_ram users and by rolz_token_decoder_unit; depends on nothing

package rolz_pkg;

  localparam int MIN_LEN      = 4;
  localparam int MAX_LEN      = 255;
  localparam int RING_ENTRIES = 4096;
  localparam int BLOCK_BYTES  = 65536;
  localparam int CONTEXTS     = 256;
  localparam int LIT_LIMIT    = 256;

  localparam int BYTE_W  = 8;
  localparam int LANES   = 8;
  localparam int LANE_W  = $clog2(LANES);
  localparam int CTX_W   = $clog2(CONTEXTS);
  localparam int RING_W  = $clog2(RING_ENTRIES);
  localparam int RING_AW = CTX_W + RING_W;
  localparam int HIST_AW = $clog2(BLOCK_BYTES);
  localparam int POS_W   = HIST_AW + 1;
  localparam int SYM_W   = 9;
  localparam int IDX_W   = 12;
  localparam int LEN_W   = 9;
  localparam int CNT_W   = 4;

  typedef struct packed {
    logic              start_block;
    logic [SYM_W-1:0]  symbol;
    logic [IDX_W-1:0]  match_index;
  } in_word_t;

  typedef struct packed {
    logic [LANES*BYTE_W-1:0] out_bytes;
    logic [CNT_W-1:0]        byte_count;
    logic                    last;
    logic                    error;
  } out_word_t;

endpackage

@@ rtl/rolz_ram.sv @@
// rolz_ram: generic simple dual-port ram, one write port and one registered read port
// no package dependency; instanced for history, ring heads and ring positions

module rolz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rolz_token_decoder_unit.sv @@
// rolz_token_decoder_unit: reduced-offset lz token decoder top level
// uses rolz_pkg for types and constants and rolz_ram for history, heads and ring positions
//
//   channel | handshake           | word
//   --------+---------------------+------------------------------------------
//   in      | in_valid / in_stall | start_block, symbol, match_index
//   out     | out_valid/out_stall | out_bytes, byte_count, last, error
//
// a literal at block start goes to S_EMIT; any other reads the head ram, then writes it
// a match does a head read, then a ring read and record, then copies each result word:
// the history ram has one read and one write port, so within a word bytes copy one a cycle
// a token rejected at acceptance goes to S_EMIT, one rejected on its ring entry from S_RING
// reset is synchronous and needs no clearing pass
// ring heads carry per-context valid flops, ring entries are judged live from head and wrap
// out_stall holds the output register and S_EMIT; a token is taken while a word waits there

module rolz_token_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rolz_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rolz_pkg::out_word_t out_data
);
  import rolz_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HEAD = 5'b00010,
    S_RING = 5'b00100,
    S_COPY = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    wpos_r, wpos_nxt;
  logic [BYTE_W-1:0]   last_byte_r, last_byte_nxt;
  logic [CONTEXTS-1:0] head_vld_r, head_vld_nxt;
  logic                is_lit_r, is_lit_nxt;
  logic [CTX_W-1:0]    ctx_r, ctx_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [RING_W-1:0]   idx_r, idx_nxt;
  logic [RING_W-1:0]   head_cur_r, head_cur_nxt;
  logic                wrap_r, wrap_nxt;
  logic                ring_ok_r, ring_ok_nxt;
  logic [HIST_AW-1:0]  src_r, src_nxt;
  logic [LEN_W-1:0]    rd_k_r, rd_k_nxt;
  logic [LEN_W-1:0]    wr_k_r, wr_k_nxt;
  logic [LEN_W-1:0]    base_r, base_nxt;
  logic [LEN_W-1:0]    chunk_end_r, chunk_end_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic                fwd_r;
  logic [BYTE_W-1:0]   fwd_data_r;
  out_word_t           res_r, res_nxt;
  logic                out_valid_r;
  out_word_t           out_data_r;

  logic                accept;
  logic                out_free;
  logic [POS_W-1:0]    acc_pos;
  logic                acc_lit;
  logic [LEN_W-1:0]    acc_len;
  logic [POS_W-1:0]    room;
  logic                lit_err;
  logic                mat_err;
  out_word_t           err_word;
  out_word_t           lit_word;

  logic [RING_W:0]     head_rdata;
  logic                head_valid;
  logic [RING_W-1:0]   head_now;
  logic                wrap_now;
  logic [RING_W-1:0]   node;
  logic                node_ok;
  logic [RING_W-1:0]   rec_base;
  logic                rec_wrap_in;
  logic [RING_W-1:0]   rec_h;
  logic                rec_wrap;
  logic                rec_en;

  logic [HIST_AW-1:0]  ring_rdata;
  logic [HIST_AW-1:0]  ring_src;
  logic                src_bad;

  logic                hist_we;
  logic [HIST_AW-1:0]  hist_waddr;
  logic [BYTE_W-1:0]   hist_wdata;
  logic [HIST_AW-1:0]  hist_raddr;
  logic [BYTE_W-1:0]   hist_rdata;
  logic [BYTE_W-1:0]   cp_data;
  logic [LANE_W-1:0]   lane;
  logic [LEN_W-1:0]    next_sum;
  logic [LEN_W-1:0]    next_end;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // token decode at acceptance, after any block clear
  assign acc_pos = in_data.start_block ? '0 : wpos_r;
  assign acc_lit = (in_data.symbol < SYM_W'(LIT_LIMIT));
  assign acc_len = LEN_W'(in_data.symbol[BYTE_W-1:0]) + LEN_W'(MIN_LEN);
  assign room    = POS_W'(BLOCK_BYTES) - acc_pos;
  assign lit_err = (acc_pos >= POS_W'(BLOCK_BYTES));
  assign mat_err = (acc_pos == '0) || (acc_len > LEN_W'(MAX_LEN))
                   || (acc_pos > POS_W'(BLOCK_BYTES)) || (POS_W'(acc_len) > room);

  always_comb begin
    err_word = '0;
    err_word.last  = 1'b1;
    err_word.error = 1'b1;
    lit_word = '0;
    lit_word.out_bytes  = (LANES*BYTE_W)'(in_data.symbol[BYTE_W-1:0]);
    lit_word.byte_count = CNT_W'(1);
    lit_word.last       = 1'b1;
  end

  // context ring heads
  assign head_valid = head_vld_r[ctx_r];
  assign head_now   = head_valid ? head_rdata[RING_W-1:0] : '0;
  assign wrap_now   = head_valid ? head_rdata[RING_W] : 1'b0;
  assign node       = head_now - idx_r;
  assign node_ok    = wrap_now || ((node != '0) && (node <= head_now));

  assign rec_base    = (state_r == S_HEAD) ? head_now : head_cur_r;
  assign rec_wrap_in = (state_r == S_HEAD) ? wrap_now : wrap_r;
  assign rec_h       = rec_base + RING_W'(1);
  assign rec_wrap    = rec_wrap_in || (rec_h == '0);

  assign ring_src = ring_ok_r ? ring_rdata : '0;
  assign src_bad  = ({1'b0, ring_src} >= pos_r);
  assign rec_en   = ((state_r == S_HEAD) && is_lit_r) || ((state_r == S_RING) && !src_bad);

  rolz_ram #(
    .WIDTH(RING_W + 1),
    .DEPTH(CONTEXTS)
  ) u_head_ram (
    .clk  (clk),
    .we   (rec_en),
    .waddr(ctx_r),
    .wdata({rec_wrap, rec_h}),
    .raddr(last_byte_r),
    .rdata(head_rdata)
  );

  rolz_ram #(
    .WIDTH(HIST_AW),
    .DEPTH(CONTEXTS * RING_ENTRIES)
  ) u_ring_ram (
    .clk  (clk),
    .we   (rec_en),
    .waddr({ctx_r, rec_h}),
    .wdata(pos_r[HIST_AW-1:0]),
    .raddr({ctx_r, node}),
    .rdata(ring_rdata)
  );

  // byte history, written by literals and by the copy loop
  assign cp_data    = fwd_r ? fwd_data_r : hist_rdata;
  assign hist_we    = ((state_r == S_IDLE) && accept && acc_lit && !lit_err)
                      || ((state_r == S_COPY) && rd_pend_r);
  assign hist_waddr = (state_r == S_COPY) ? pos_r[HIST_AW-1:0] + HIST_AW'(wr_k_r)
                                          : acc_pos[HIST_AW-1:0];
  assign hist_wdata = (state_r == S_COPY) ? cp_data : in_data.symbol[BYTE_W-1:0];
  assign hist_raddr = src_r + HIST_AW'(rd_k_r);

  rolz_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BLOCK_BYTES)
  ) u_hist_ram (
    .clk  (clk),
    .we   (hist_we),
    .waddr(hist_waddr),
    .wdata(hist_wdata),
    .raddr(hist_raddr),
    .rdata(hist_rdata)
  );

  assign lane     = wr_k_r[LANE_W-1:0];
  assign next_sum = chunk_end_r + LEN_W'(LANES);
  assign next_end = (next_sum > len_r) ? len_r : next_sum;

  always_comb begin
    state_nxt     = state_r;
    wpos_nxt      = wpos_r;
    last_byte_nxt = last_byte_r;
    head_vld_nxt  = head_vld_r;
    is_lit_nxt    = is_lit_r;
    ctx_nxt       = ctx_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    head_cur_nxt  = head_cur_r;
    wrap_nxt      = wrap_r;
    ring_ok_nxt   = ring_ok_r;
    src_nxt       = src_r;
    rd_k_nxt      = rd_k_r;
    wr_k_nxt      = wr_k_r;
    base_nxt      = base_r;
    chunk_end_nxt = chunk_end_r;
    rd_pend_nxt   = 1'b0;
    res_nxt       = res_r;
    if (rec_en) begin
      head_vld_nxt[ctx_r] = 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt    = acc_pos;
          ctx_nxt    = last_byte_r;
          idx_nxt    = in_data.match_index[RING_W-1:0];
          len_nxt    = acc_len;
          is_lit_nxt = acc_lit;
          if (in_data.start_block) begin
            head_vld_nxt = '0;
            wpos_nxt     = '0;
          end
          if (acc_lit) begin
            if (lit_err) begin
              res_nxt   = err_word;
              state_nxt = S_EMIT;
            end else begin
              wpos_nxt      = acc_pos + POS_W'(1);
              last_byte_nxt = in_data.symbol[BYTE_W-1:0];
              res_nxt       = lit_word;
              state_nxt     = (acc_pos != '0) ? S_HEAD : S_EMIT;
            end
          end else if (mat_err) begin
            res_nxt   = err_word;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (is_lit_r) begin
          state_nxt = S_EMIT;
        end else begin
          head_cur_nxt = head_now;
          wrap_nxt     = wrap_now;
          ring_ok_nxt  = node_ok;
          state_nxt    = S_RING;
        end
      end
      S_RING: begin
        if (src_bad) begin
          res_nxt   = err_word;
          state_nxt = S_EMIT;
        end else begin
          src_nxt       = ring_src;
          wpos_nxt      = pos_r + POS_W'(len_r);
          rd_k_nxt      = '0;
          wr_k_nxt      = '0;
          base_nxt      = '0;
          chunk_end_nxt = (len_r > LEN_W'(LANES)) ? LEN_W'(LANES) : len_r;
          res_nxt       = '0;
          state_nxt     = S_COPY;
        end
      end
      S_COPY: begin
        if (rd_k_r < chunk_end_r) begin
          rd_k_nxt    = rd_k_r + LEN_W'(1);
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          res_nxt.out_bytes[lane*BYTE_W +: BYTE_W] = cp_data;
          last_byte_nxt = cp_data;
          wr_k_nxt      = wr_k_r + LEN_W'(1);
          if ((wr_k_r + LEN_W'(1)) == chunk_end_r) begin
            res_nxt.byte_count = CNT_W'(chunk_end_r - base_r);
            res_nxt.last       = (chunk_end_r == len_r);
            res_nxt.error      = 1'b0;
            state_nxt          = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (!is_lit_r && !res_r.error && !res_r.last) begin
            base_nxt      = chunk_end_r;
            chunk_end_nxt = next_end;
            res_nxt       = '0;
            state_nxt     = S_COPY;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wpos_r      <= '0;
      head_vld_r  <= '0;
      rd_pend_r   <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wpos_r     <= wpos_nxt;
      head_vld_r <= head_vld_nxt;
      rd_pend_r  <= rd_pend_nxt;
      // read and write of the same history byte in one cycle: take the written byte
      fwd_r      <= hist_we && (hist_waddr == hist_raddr);
      if ((state_r == S_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_byte_r <= last_byte_nxt;
    is_lit_r    <= is_lit_nxt;
    ctx_r       <= ctx_nxt;
    pos_r       <= pos_nxt;
    len_r       <= len_nxt;
    idx_r       <= idx_nxt;
    head_cur_r  <= head_cur_nxt;
    wrap_r      <= wrap_nxt;
    ring_ok_r   <= ring_ok_nxt;
    src_r       <= src_nxt;
    rd_k_r      <= rd_k_nxt;
    wr_k_r      <= wr_k_nxt;
    base_r      <= base_nxt;
    chunk_end_r <= chunk_end_nxt;
    res_r       <= res_nxt;
    fwd_data_r  <= hist_wdata;
    if ((state_r == S_EMIT) && out_free) begin
      out_data_r <= res_r;
    end
  end

`ifndef SYNTHESIS
  a_pend_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == S_COPY))
    else $error("history read pending outside copy");

  a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> ((wr_k_r <= rd_k_r) && (rd_k_r <= chunk_end_r)))
    else $error("copy counters out of order");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error) |-> ((out_data_r.byte_count == '0) && out_data_r.last))
    else $error("error word carries bytes");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= POS_W'(BLOCK_BYTES))
    else $error("write position beyond block");
`endif

endmodule

@@ tb/sv/rolz_token_decoder_unit_test.sv @@
// rolz_token_decoder_unit_test: self-checking bench for the reduced-offset lz token decoder
// drives tokens through a directed table, a full-block fill and a random run, predicting
// untyped tokens' words with its own history and context rings; depends on rolz_pkg, the unit

module rolz_token_decoder_unit_test;
  import rolz_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 50;
  localparam int SETTLE       = 40;

  localparam out_word_t REJECTED = '{out_bytes: '0, byte_count: '0, last: 1'b1, error: 1'b1};

  typedef struct packed {
    in_word_t  tok;
    logic      typed;
    out_word_t want;
  } stim_row_t;

  // start, symbol, index, typed, bytes, count, last, error
  localparam int DIRECTED_ROWS = 20;
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    {1'b0, 9'd256,  12'h000, 1'b1, REJECTED},
    {1'b0, 9'h000,  12'hfff, 1'b1, 64'h00, 4'd1, 1'b1, 1'b0},
    {1'b0, 9'h0ff,  12'h000, 1'b1, 64'hff, 4'd1, 1'b1, 1'b0},
    {1'b0, 9'd256,  12'h000, 1'b0, 70'd0},
    {1'b0, 9'd507,  12'hfff, 1'b0, 70'd0},
    {1'b0, 9'd508,  12'h000, 1'b1, REJECTED},
    {1'b0, 9'd511,  12'hfff, 1'b1, REJECTED},
    {1'b1, 9'h055,  12'h000, 1'b1, 64'h55, 4'd1, 1'b1, 1'b0},
    {1'b1, 9'd300,  12'h123, 1'b1, REJECTED},
    {1'b0, 9'h0aa,  12'h000, 1'b1, 64'haa, 4'd1, 1'b1, 1'b0},
    {1'b0, 9'h001,  12'h000, 1'b1, 64'h01, 4'd1, 1'b1, 1'b0},
    {1'b0, 9'd260,  12'h000, 1'b0, 70'd0},
    {1'b0, 9'd261,  12'h000, 1'b0, 70'd0},
    {1'b0, 9'd268,  12'h001, 1'b0, 70'd0},
    {1'b0, 9'h080,  12'h800, 1'b1, 64'h80, 4'd1, 1'b1, 1'b0},
    {1'b0, 9'd256,  12'h800, 1'b0, 70'd0},
    {1'b1, 9'h07f,  12'hfff, 1'b1, 64'h7f, 4'd1, 1'b1, 1'b0},
    {1'b0, 9'd259,  12'h005, 1'b0, 70'd0},
    {1'b0, 9'h155,  12'haaa, 1'b0, 70'd0},
    {1'b0, 9'h0aa,  12'h555, 1'b1, 64'haa, 4'd1, 1'b1, 1'b0}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  // predictor state
  bit [BYTE_W-1:0] hist [BLOCK_BYTES];
  bit [RING_W-1:0] heads [CONTEXTS];
  int unsigned     ring_pos [int unsigned];
  bit [POS_W-1:0]  wr_pos = '0;

  out_word_t decoded_words [$];
  out_word_t pending_out_words [$];

  int unsigned cycles        = 0;
  int unsigned mismatches    = 0;
  int unsigned tokens_sent   = 0;
  int unsigned words_checked = 0;
  int unsigned rejects_seen  = 0;
  int unsigned stall_left    = 0;
  bit          calm          = 1'b0;

  rolz_token_decoder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stalls: short bursts mostly, some long ones, none start while calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall || calm) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(30, 1);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
    end
  end

  function automatic in_word_t tok(bit start, int unsigned sym, int unsigned idx);
    in_word_t w;
    w.start_block = start;
    w.symbol      = sym[SYM_W-1:0];
    w.match_index = idx[IDX_W-1:0];
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  function automatic void record_pos(int unsigned ctx, int unsigned pos);
    int unsigned h;
    h = (heads[ctx] + 1) % RING_ENTRIES;
    heads[ctx] = h[RING_W-1:0];
    ring_pos[ctx * RING_ENTRIES + h] = pos;
  endfunction

  // fills decoded_words with the words one token produces and advances the state
  function automatic void decode_token(in_word_t w);
    int unsigned pos, len, ctx, node, src, key, k, b, cnt;
    out_word_t o;
    decoded_words.delete();
    if (w.start_block) begin
      foreach (heads[i]) heads[i] = '0;
      ring_pos.delete();
      wr_pos = '0;
    end
    pos = 32'(wr_pos);
    if (w.symbol < LIT_LIMIT) begin
      if (pos >= BLOCK_BYTES) begin
        decoded_words.push_back(REJECTED);
        return;
      end
      hist[pos] = w.symbol[BYTE_W-1:0];
      if (pos > 0) record_pos(32'(hist[pos-1]), pos);
      wr_pos = POS_W'(pos + 1);
      o = '0;
      o.out_bytes  = (LANES*BYTE_W)'(w.symbol[BYTE_W-1:0]);
      o.byte_count = CNT_W'(1);
      o.last       = 1'b1;
      decoded_words.push_back(o);
      return;
    end
    len = w.symbol - LIT_LIMIT + MIN_LEN;
    if (pos == 0 || len > MAX_LEN || pos > BLOCK_BYTES || len > BLOCK_BYTES - pos) begin
      decoded_words.push_back(REJECTED);
      return;
    end
    ctx  = 32'(hist[pos-1]);
    node = (heads[ctx] + RING_ENTRIES - (w.match_index % RING_ENTRIES)) % RING_ENTRIES;
    key  = ctx * RING_ENTRIES + node;
    src  = ring_pos.exists(key) ? ring_pos[key] : 0;
    if (src >= pos) begin
      decoded_words.push_back(REJECTED);
      return;
    end
    record_pos(ctx, pos);
    // byte by byte so overlapping copies repeat the pattern
    for (k = 0; k < len; k++) hist[pos+k] = hist[src+k];
    wr_pos = POS_W'(pos + len);
    for (k = 0; k < len; k += LANES) begin
      cnt = (len - k < LANES) ? len - k : LANES;
      o = '0;
      for (b = 0; b < cnt; b++) o.out_bytes[BYTE_W*b +: BYTE_W] = hist[pos+k+b];
      o.byte_count = CNT_W'(cnt);
      o.last       = (k + LANES >= len);
      decoded_words.push_back(o);
    end
  endfunction

  task automatic send_token(in_word_t w, bit typed, out_word_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    decode_token(w);
    if (typed) begin
      pending_out_words.push_back(want);
    end else begin
      foreach (decoded_words[i]) pending_out_words.push_back(decoded_words[i]);
    end
    tokens_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_out_words.size() != 0) @(posedge clk);
  endtask

  task automatic report_bad(string what, out_word_t want, out_word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at cycle %0d: expected bytes %h count %0d last %0b error %0b",
               what, cycles, want.out_bytes, want.byte_count, want.last, want.error);
      $display("  got bytes %h count %0d last %0b error %0b",
               got.out_bytes, got.byte_count, got.last, got.error);
    end
  endtask

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_out_words.size() == 0) begin
        report_bad("unexpected word", '0, out_data);
      end else begin
        want = pending_out_words.pop_front();
        if (out_data.out_bytes !== want.out_bytes || out_data.byte_count !== want.byte_count
            || out_data.last !== want.last || out_data.error !== want.error)
          report_bad("word mismatch", want, out_data);
        words_checked++;
        if (want.error) rejects_seen++;
      end
    end
  end

  initial begin : stimulus
    int unsigned n, rem, r, sym, idx;
    bit start;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIRECTED_ROWS; n++)
      send_token(directed_rows[n].tok, directed_rows[n].typed, directed_rows[n].want);
    drain();

    // fill one whole block with long matches, then run past its end
    send_token(tok(1, 'h31, 0), 1'b0, '0);
    send_token(tok(0, 'h32, 0), 1'b0, '0);
    while (BLOCK_BYTES - wr_pos > 261)
      send_token(tok(0, 507, $urandom_range(3)), 1'b0, '0);
    rem = BLOCK_BYTES - wr_pos;
    if (rem - 6 >= MIN_LEN) begin
      send_token(tok(0, rem - 6 - MIN_LEN + LIT_LIMIT, $urandom_range(3)), 1'b0, '0);
    end else begin
      while (BLOCK_BYTES - wr_pos > 6) send_token(tok(0, $urandom_range(255), 0), 1'b0, '0);
    end
    send_token(tok(0, LIT_LIMIT + 7 - MIN_LEN, 0), 1'b0, '0);
    send_token(tok(0, LIT_LIMIT + 6 - MIN_LEN, 0), 1'b0, '0);
    send_token(tok(0, 'h5a, 0), 1'b0, '0);
    send_token(tok(0, LIT_LIMIT, 0), 1'b0, '0);
    drain();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm  = (n >= 15 && n < 30);
      start = (n == 0) || ($urandom_range(99) < 3);
      if ($urandom_range(99) < 45) begin
        sym = ($urandom_range(3) == 0) ? $urandom_range(255) : 'h41 + $urandom_range(3);
      end else begin
        r = $urandom_range(99);
        if (r < 70)      sym = LIT_LIMIT + $urandom_range(12);
        else if (r < 92) sym = LIT_LIMIT + $urandom_range(60);
        else if (r < 97) sym = LIT_LIMIT + $urandom_range(251);
        else             sym = LIT_LIMIT + $urandom_range(255, 252);
      end
      idx = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(7);
      send_token(tok(start, sym, idx), 1'b0, '0);
    end
    calm = 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d tokens and %0d output words, %0d of them rejections,",
             tokens_sent, words_checked, rejects_seen);
    $display("including one block filled to its %0d byte end and tokens past it", BLOCK_BYTES);
    if (mismatches == 0 && pending_out_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
